// ===== hw/rtl/triangle_sign_localizer_defines.svh =====
// Assertion helpers used by the localizer top-level RTL.
// Both macros expect signals named clk and rst_n in the scope that uses them.
`ifndef TRIANGLE_SIGN_LOCALIZER_DEFINES_SVH
`define TRIANGLE_SIGN_LOCALIZER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tsl_pkg.sv =====
package tsl_pkg;

    // Only polygons with this many vertices can be a sign.
    localparam logic [3:0] SIDES = 4'd3;

    // The viewer stands this many pixels below the bottom frame edge.
    localparam int VIEWER_DROP = 150;

    // Angles in 1/64 degree.
    localparam logic signed [15:0] ANG_90  = 16'sd5760;
    localparam logic signed [15:0] ANG_180 = 16'sd11520;
    localparam logic signed [15:0] ANG_270 = 16'sd17280;
    localparam logic signed [15:0] ANG_360 = 16'sd23040;
    localparam int ANGW = 13;

    // Vectoring rotator: atan(2^-i) in 1/65536 degree.
    localparam int CORDIC_STEPS = 22;
    localparam int ZW = 25;
    localparam logic signed [ZW-1:0] Z_MAX = 25'sd5898240;
    localparam logic signed [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
        25'sd117304, 25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334,
        25'sd3667, 25'sd1833, 25'sd917, 25'sd458, 25'sd229, 25'sd115,
        25'sd57, 25'sd29, 25'sd14, 25'sd7, 25'sd4, 25'sd2
    };

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIDE_TOL   = 3'd0,
        CFG_MIN_SIDE   = 3'd1,
        CFG_OFFSET_X   = 3'd2,
        CFG_OFFSET_Y   = 3'd3,
        CFG_FRAME_W    = 3'd4,
        CFG_FRAME_H    = 3'd5,
        CFG_DIST_SCALE = 3'd6
    } cfg_index_t;

    // How the apex angle maps onto the full circle.
    typedef enum logic [1:0] {
        ORI_HALF,
        ORI_PLAIN,
        ORI_FULL,
        ORI_FIXED
    } orient_case_t;

endpackage

// ===== hw/rtl/tsl_isqrt.sv =====
// Pipelined integer square root (floor), SPS result bits per stage.
module tsl_isqrt #(
    parameter int W   = 26,
    parameter int SPS = 2,
    parameter int SBW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [W-1:0]     in_value,
    input  logic [SBW-1:0]   in_side,
    output logic             out_valid,
    output logic [W/2-1:0]   out_root,
    output logic [SBW-1:0]   out_side
);

    localparam int STEPS = W / 2;
    localparam int NST   = (STEPS + SPS - 1) / SPS;
    localparam int RW    = W / 2 + 3;

    logic [W-1:0]     val_cur   [NST+1];
    logic [RW-1:0]    rem_cur   [NST+1];
    logic [W/2-1:0]   root_cur  [NST+1];
    logic [SBW-1:0]   side_cur  [NST+1];
    logic             valid_cur [NST+1];

    logic [W-1:0]     val_next  [NST];
    logic [RW-1:0]    rem_next  [NST];
    logic [W/2-1:0]   root_next [NST];

    logic [W-1:0]     val_reg   [NST];
    logic [RW-1:0]    rem_reg   [NST];
    logic [W/2-1:0]   root_reg  [NST];
    logic [SBW-1:0]   side_reg  [NST];
    logic             valid_reg [NST];

    assign val_cur[0]   = in_value;
    assign rem_cur[0]   = '0;
    assign root_cur[0]  = '0;
    assign side_cur[0]  = in_side;
    assign valid_cur[0] = in_valid;

    for (genvar s = 0; s < NST; s++) begin : g_stage
        always_comb
        begin
            logic [W-1:0]   v;
            logic [RW-1:0]  r;
            logic [RW-1:0]  r2;
            logic [RW-1:0]  trial;
            logic [W/2-1:0] q;
            v = val_cur[s];
            r = rem_cur[s];
            q = root_cur[s];
            for (int k = 0; k < SPS; k++)
            begin
                if (s * SPS + k < STEPS)
                begin
                    r2    = {r[RW-3:0], v[W-1:W-2]};
                    trial = RW'({q, 2'b01});
                    if (r2 >= trial)
                    begin
                        r = r2 - trial;
                        q = {q[W/2-2:0], 1'b1};
                    end
                    else
                    begin
                        r = r2;
                        q = {q[W/2-2:0], 1'b0};
                    end
                    v = {v[W-3:0], 2'b00};
                end
            end
            val_next[s]  = v;
            rem_next[s]  = r;
            root_next[s] = q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_cur[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                val_reg[s]  <= val_next[s];
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                side_reg[s] <= side_cur[s];
            end
        end

        assign val_cur[s+1]   = val_reg[s];
        assign rem_cur[s+1]   = rem_reg[s];
        assign root_cur[s+1]  = root_reg[s];
        assign side_cur[s+1]  = side_reg[s];
        assign valid_cur[s+1] = valid_reg[s];
    end

    assign out_valid = valid_cur[NST];
    assign out_root  = root_cur[NST];
    assign out_side  = side_cur[NST];

endmodule

// ===== hw/rtl/tsl_cordic.sv =====
// Pipelined vectoring rotator: atan(num/den) in 1/64 degree, 0..90 degrees.
module tsl_cordic #(
    parameter int MW  = 13,
    parameter int SPS = 2,
    parameter int SBW = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [MW-1:0]             in_num,
    input  logic [MW-1:0]             in_den,
    input  logic [SBW-1:0]            in_side,
    output logic                      out_valid,
    output logic [tsl_pkg::ANGW-1:0]  out_angle,
    output logic [SBW-1:0]            out_side
);

    localparam int XW  = MW + 19;
    localparam int ZW  = tsl_pkg::ZW;
    localparam int NST = (tsl_pkg::CORDIC_STEPS + SPS - 1) / SPS;

    logic signed [XW-1:0] x_cur [NST+1];
    logic signed [XW-1:0] y_cur [NST+1];
    logic signed [ZW-1:0] z_cur [NST+1];
    logic [SBW-1:0]       side_cur  [NST+1];
    logic                 valid_cur [NST+1];

    logic signed [XW-1:0] x_next [NST];
    logic signed [XW-1:0] y_next [NST];
    logic signed [ZW-1:0] z_next [NST];

    logic signed [XW-1:0] x_reg [NST];
    logic signed [XW-1:0] y_reg [NST];
    logic signed [ZW-1:0] z_reg [NST];
    logic [SBW-1:0]       side_reg  [NST];
    logic                 valid_reg [NST];

    logic signed [ZW-1:0] z_clamp;
    logic signed [ZW-1:0] z_round;

    assign x_cur[0]     = $signed({3'b000, in_den, 16'd0});
    assign y_cur[0]     = $signed({3'b000, in_num, 16'd0});
    assign z_cur[0]     = '0;
    assign side_cur[0]  = in_side;
    assign valid_cur[0] = in_valid;

    for (genvar s = 0; s < NST; s++) begin : g_stage
        always_comb
        begin
            logic signed [XW-1:0] x;
            logic signed [XW-1:0] y;
            logic signed [XW-1:0] sx;
            logic signed [XW-1:0] sy;
            logic signed [ZW-1:0] z;
            int idx;
            x  = x_cur[s];
            y  = y_cur[s];
            z  = z_cur[s];
            sx = '0;
            sy = '0;
            for (int k = 0; k < SPS; k++)
            begin
                idx = s * SPS + k;
                // Once the residue reaches zero the remaining steps do nothing.
                if (idx < tsl_pkg::CORDIC_STEPS && y != '0)
                begin
                    sx = y[XW-1] ? -((-y) >>> idx) : (y >>> idx);
                    sy = x >>> idx;
                    if (!y[XW-1])
                    begin
                        x = x + sx;
                        y = y - sy;
                        z = z + tsl_pkg::ATAN_TAB[idx];
                    end
                    else
                    begin
                        x = x - sx;
                        y = y + sy;
                        z = z - tsl_pkg::ATAN_TAB[idx];
                    end
                end
            end
            x_next[s] = x;
            y_next[s] = y;
            z_next[s] = z;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_cur[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= x_next[s];
                y_reg[s]    <= y_next[s];
                z_reg[s]    <= z_next[s];
                side_reg[s] <= side_cur[s];
            end
        end

        assign x_cur[s+1]     = x_reg[s];
        assign y_cur[s+1]     = y_reg[s];
        assign z_cur[s+1]     = z_reg[s];
        assign side_cur[s+1]  = side_reg[s];
        assign valid_cur[s+1] = valid_reg[s];
    end

    // Clamp to 0..90 degrees and round half up to 1/64 degree.
    always_comb
    begin
        if (z_cur[NST] < 0)
            z_clamp = '0;
        else if (z_cur[NST] > tsl_pkg::Z_MAX)
            z_clamp = tsl_pkg::Z_MAX;
        else
            z_clamp = z_cur[NST];
        z_round = z_clamp + 25'sd512;
    end

    assign out_angle = z_round[tsl_pkg::ANGW+9:10];
    assign out_valid = valid_cur[NST];
    assign out_side  = side_cur[NST];

endmodule

// ===== hw/rtl/triangle_sign_localizer.sv =====
// Triangle sign localizer.
// The slave stream carries one polygon candidate per transaction: a vertex
// count and three vertices in region-of-interest pixels. The master stream
// returns exactly one result transaction per polygon, in order: a sign flag,
// the scaled distance from the viewer to the triangle centre (4 fraction bits),
// the apex orientation and the bearing, both in 1/64 degree. Rejected
// polygons come back with all fields zero.
// The pipeline takes one polygon every cycle unless the receiver stalls. With
// 12-bit coordinates it holds the side length root (7 stages), the distance
// root (15 stages), the angle rotators (11 stages) and 9 stages of glue.
// When the receiver stalls, the whole pipeline freezes and tready drops, so
// nothing is lost or repeated; one stage of holding frees up as soon as the
// output transaction is taken. The user must write registers through the config
// port only while idle, which the block does not enforce. Reset empties the
// pipeline and loads the default register values; no clearing pass is needed.
`include "triangle_sign_localizer_defines.svh"

module triangle_sign_localizer #(
    parameter int COORD_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // vertex_count[3:0], vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
    // vertex_c_x, vertex_c_y (COORD_BITS each), zero padding
    input  logic [((4 + 6 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // is_sign[0], distance[32:1], orientation[47:33], bearing[61:48], zero padding
    output logic [tsl_pkg::OUT_W-1:0] m_axis_tdata,

    input  logic                            cfg_wr_en,
    input  logic [tsl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsl_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int PW   = ((CB > 12) ? CB : 12) + 1;  // coordinate after offset
    localparam int SQW  = 2 * CB + 2;                 // raw side root input
    localparam int LW   = SQW / 2;
    localparam int DW2  = 2 * PW + 1;
    localparam int PRW  = DW2 + 32;
    localparam int DSW  = PRW + 1;
    localparam int RTW  = DSW / 2;
    localparam int ANGW = tsl_pkg::ANGW;
    localparam int DSB  = 1 + 4 * PW + 5;
    localparam int OSB  = 1 + 32 + 3;

    // Configuration registers.
    logic [11:0] tol_reg;
    logic [11:0] min_reg;
    logic [11:0] offx_reg;
    logic [11:0] offy_reg;
    logic [11:0] fw_reg;
    logic [11:0] fh_reg;
    logic [15:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= 12'd10;
            min_reg   <= 12'd20;
            offx_reg  <= 12'd0;
            offy_reg  <= 12'd0;
            fw_reg    <= 12'd640;
            fh_reg    <= 12'd480;
            scale_reg <= 16'd256;
        end
        else if (cfg_wr_en)
        begin
            case (tsl_pkg::cfg_index_t'(cfg_index))
                tsl_pkg::CFG_SIDE_TOL:   tol_reg   <= cfg_data[11:0];
                tsl_pkg::CFG_MIN_SIDE:   min_reg   <= cfg_data[11:0];
                tsl_pkg::CFG_OFFSET_X:   offx_reg  <= cfg_data[11:0];
                tsl_pkg::CFG_OFFSET_Y:   offy_reg  <= cfg_data[11:0];
                tsl_pkg::CFG_FRAME_W:    fw_reg    <= cfg_data[11:0];
                tsl_pkg::CFG_FRAME_H:    fh_reg    <= cfg_data[11:0];
                tsl_pkg::CFG_DIST_SCALE: scale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [CB-1:0] adiff_c(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [LW-1:0] adiff_l(input logic [LW-1:0] a, input logic [LW-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic [PW-1:0] adiff_p(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // a + (b - a) / 2 with the halving truncated toward zero.
    function automatic logic [PW-1:0] mid_tz(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [PW-1:0] h;
        if (b >= a)
        begin
            h = (b - a) >> 1;
            return a + h;
        end
        h = (a - b) >> 1;
        return a - h;
    endfunction

    function automatic logic [PW-1:0] mag_p(input logic signed [PW:0] v);
        logic signed [PW:0] m;
        m = v[PW] ? -v : v;
        return m[PW-1:0];
    endfunction

    // The whole pipeline moves whenever the output register can take a result.
    logic out_valid_reg;
    logic adv;
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = out_valid_reg;

    // Stage 0: input capture.
    logic          v0_reg;
    logic [3:0]    cnt0_reg;
    logic [CB-1:0] x0_reg [3];
    logic [CB-1:0] y0_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cnt0_reg  <= s_axis_tdata[3:0];
            x0_reg[0] <= s_axis_tdata[4 +: CB];
            y0_reg[0] <= s_axis_tdata[4 + CB +: CB];
            x0_reg[1] <= s_axis_tdata[4 + 2 * CB +: CB];
            y0_reg[1] <= s_axis_tdata[4 + 3 * CB +: CB];
            x0_reg[2] <= s_axis_tdata[4 + 4 * CB +: CB];
            y0_reg[2] <= s_axis_tdata[4 + 5 * CB +: CB];
        end
    end

    // Stage 1: squared raw side lengths ab, bc, ca.
    logic [SQW-1:0] sum1_next [3];
    logic [SQW-1:0] sum1_reg  [3];
    logic           v1_reg;
    logic           cok1_reg;
    logic [CB-1:0]  x1_reg [3];
    logic [CB-1:0]  y1_reg [3];

    always_comb
    begin
        logic [CB-1:0]   ax;
        logic [CB-1:0]   ay;
        logic [2*CB-1:0] qx;
        logic [2*CB-1:0] qy;
        for (int i = 0; i < 3; i++)
        begin
            ax = adiff_c(x0_reg[i], x0_reg[(i + 1) % 3]);
            ay = adiff_c(y0_reg[i], y0_reg[(i + 1) % 3]);
            qx = ax * ax;
            qy = ay * ay;
            sum1_next[i] = qx + qy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum1_reg <= sum1_next;
            cok1_reg <= (cnt0_reg == tsl_pkg::SIDES);
            x1_reg   <= x0_reg;
            y1_reg   <= y0_reg;
        end
    end

    // Side length roots, three lanes side by side.
    logic          vq0, vq1, vq2;
    logic [LW-1:0] len [3];
    logic [CB-1:0] qx_a, qy_a, qx_b, qy_b, qx_c, qy_c;
    logic          cok_q;

    tsl_isqrt #(.W(SQW), .SPS(2), .SBW(4 * CB)) u_len_ab (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v1_reg),
        .in_value(sum1_reg[0]),
        .in_side({x1_reg[0], y1_reg[0], x1_reg[1], y1_reg[1]}),
        .out_valid(vq0), .out_root(len[0]),
        .out_side({qx_a, qy_a, qx_b, qy_b})
    );

    tsl_isqrt #(.W(SQW), .SPS(2), .SBW(2 * CB)) u_len_bc (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v1_reg),
        .in_value(sum1_reg[1]),
        .in_side({x1_reg[2], y1_reg[2]}),
        .out_valid(vq1), .out_root(len[1]),
        .out_side({qx_c, qy_c})
    );

    tsl_isqrt #(.W(SQW), .SPS(2), .SBW(1)) u_len_ca (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v1_reg),
        .in_value(sum1_reg[2]),
        .in_side(cok1_reg),
        .out_valid(vq2), .out_root(len[2]),
        .out_side(cok_q)
    );

    // Stage 2: shape and size checks, region offset.
    logic          v2_reg;
    logic          ok2_reg;
    logic [PW-1:0] px2_reg [3];
    logic [PW-1:0] py2_reg [3];
    logic          ok2_next;

    always_comb
    begin
        ok2_next = cok_q
            && (adiff_l(len[0], len[1]) < tol_reg)
            && (adiff_l(len[1], len[2]) < tol_reg)
            && (adiff_l(len[2], len[0]) < tol_reg)
            && (len[0] >= min_reg) && (len[1] >= min_reg) && (len[2] >= min_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= vq0 && vq1 && vq2;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok2_reg    <= ok2_next;
            px2_reg[0] <= PW'(qx_a) + PW'(offx_reg);
            py2_reg[0] <= PW'(qy_a) + PW'(offy_reg);
            px2_reg[1] <= PW'(qx_b) + PW'(offx_reg);
            py2_reg[1] <= PW'(qy_b) + PW'(offy_reg);
            px2_reg[2] <= PW'(qx_c) + PW'(offx_reg);
            py2_reg[2] <= PW'(qy_c) + PW'(offy_reg);
        end
    end

    // Stage 3: squared lengths of the shifted sides 12, 13, 23.
    logic           v3_reg;
    logic           ok3_reg;
    logic [PW-1:0]  px3_reg [3];
    logic [PW-1:0]  py3_reg [3];
    logic [DW2-1:0] s3_next [3];
    logic [DW2-1:0] s3_reg  [3];

    always_comb
    begin
        logic [PW-1:0]   ax;
        logic [PW-1:0]   ay;
        logic [2*PW-1:0] qx;
        logic [2*PW-1:0] qy;
        for (int i = 0; i < 3; i++)
        begin
            // Pairs 0-1, 0-2, 1-2.
            ax = adiff_p(px2_reg[i / 2], px2_reg[(i + 3) / 2]);
            ay = adiff_p(py2_reg[i / 2], py2_reg[(i + 3) / 2]);
            qx = ax * ax;
            qy = ay * ay;
            s3_next[i] = qx + qy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok3_reg <= ok2_reg;
            px3_reg <= px2_reg;
            py3_reg <= py2_reg;
            s3_reg  <= s3_next;
        end
    end

    // Stage 4: longest side and apex; midpoint of the longest side.
    logic          v4_reg;
    logic          ok4_reg;
    logic [PW-1:0] pcx4_reg, pcy4_reg, mabx4_reg, maby4_reg;
    logic [PW-1:0] pax, pay, pbx, pby, pcx, pcy;

    always_comb
    begin
        if (s3_reg[0] > s3_reg[1] && s3_reg[0] > s3_reg[2])
        begin
            pax = px3_reg[0]; pay = py3_reg[0];
            pbx = px3_reg[1]; pby = py3_reg[1];
            pcx = px3_reg[2]; pcy = py3_reg[2];
        end
        else if (s3_reg[1] > s3_reg[0] && s3_reg[1] > s3_reg[2])
        begin
            pax = px3_reg[0]; pay = py3_reg[0];
            pbx = px3_reg[2]; pby = py3_reg[2];
            pcx = px3_reg[1]; pcy = py3_reg[1];
        end
        else
        begin
            // Ties fall back to side 23 with the first vertex as apex.
            pax = px3_reg[1]; pay = py3_reg[1];
            pbx = px3_reg[2]; pby = py3_reg[2];
            pcx = px3_reg[0]; pcy = py3_reg[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok4_reg   <= ok3_reg;
            pcx4_reg  <= pcx;
            pcy4_reg  <= pcy;
            mabx4_reg <= mid_tz(pax, pbx);
            maby4_reg <= mid_tz(pay, pby);
        end
    end

    // Stage 5: triangle centre and apex direction.
    logic               v5_reg;
    logic               ok5_reg;
    logic [PW-1:0]      mtx5_reg, mty5_reg;
    logic signed [PW:0] dx5_reg, dy5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (adv)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok5_reg  <= ok4_reg;
            mtx5_reg <= mid_tz(pcx4_reg, mabx4_reg);
            mty5_reg <= mid_tz(pcy4_reg, maby4_reg);
            dx5_reg  <= $signed({1'b0, pcx4_reg}) - $signed({1'b0, mabx4_reg});
            dy5_reg  <= $signed({1'b0, pcy4_reg}) - $signed({1'b0, maby4_reg});
        end
    end

    // Stage 6: offset from the viewer, squared distance, squared scale.
    logic               v6_reg;
    logic               ok6_reg;
    logic signed [PW:0] dx6_reg, dy6_reg, bx6_reg, by6_reg;
    logic [DW2-1:0]     d2_6_reg;
    logic [31:0]        ss6_reg;
    logic [PW-1:0]      tx, ty;
    logic [DW2-1:0]     d2_next;
    logic [31:0]        ss_next;

    always_comb
    begin
        logic [PW-1:0]   ax;
        logic [PW-1:0]   ay;
        logic [2*PW-1:0] qx;
        logic [2*PW-1:0] qy;
        tx = PW'(fw_reg[11:1]);
        ty = PW'(fh_reg) + PW'(tsl_pkg::VIEWER_DROP);
        ax = adiff_p(mtx5_reg, tx);
        ay = adiff_p(mty5_reg, ty);
        qx = ax * ax;
        qy = ay * ay;
        d2_next = qx + qy;
        ss_next = scale_reg * scale_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (adv)
            v6_reg <= v5_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok6_reg  <= ok5_reg;
            dx6_reg  <= dx5_reg;
            dy6_reg  <= dy5_reg;
            bx6_reg  <= $signed({1'b0, mtx5_reg}) - $signed({1'b0, tx});
            by6_reg  <= $signed({1'b0, mty5_reg}) - $signed({1'b0, ty});
            d2_6_reg <= d2_next;
            ss6_reg  <= ss_next;
        end
    end

    // Stage 7: scaled square, rotator operands and quadrant decisions.
    logic                  v7_reg;
    logic [PRW-1:0]        prod7_reg;
    logic [DSB-1:0]        side7_reg;
    tsl_pkg::orient_case_t ocase;

    always_comb
    begin
        if (dx6_reg > 0 && dy6_reg > 0)
            ocase = tsl_pkg::ORI_HALF;
        else if (dx6_reg >= 0 && dy6_reg < 0)
            ocase = tsl_pkg::ORI_HALF;
        else if (dx6_reg < 0 && dy6_reg < 0)
            ocase = tsl_pkg::ORI_PLAIN;
        else if (dx6_reg < 0 && dy6_reg > 0)
            ocase = tsl_pkg::ORI_FULL;
        else
            ocase = tsl_pkg::ORI_FIXED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (adv)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod7_reg <= d2_6_reg * ss6_reg;
            // A vertical apex direction is treated as a unit step in x.
            side7_reg <= {ok6_reg,
                          mag_p(dy6_reg),
                          (dx6_reg == 0) ? PW'(1) : mag_p(dx6_reg),
                          mag_p(by6_reg),
                          mag_p(bx6_reg),
                          ocase,
                          dy6_reg[PW] != dx6_reg[PW],
                          bx6_reg == 0,
                          by6_reg[PW] != bx6_reg[PW]};
        end
    end

    // Distance root.
    logic                  vd;
    logic [RTW-1:0]        droot;
    logic                  ok_d;
    logic [PW-1:0]         onum_d, oden_d, bnum_d, bden_d;
    tsl_pkg::orient_case_t ocase_d;
    logic                  oneg_d, bzero_d, bneg_d;

    tsl_isqrt #(.W(DSW), .SPS(2), .SBW(DSB)) u_dist (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(v7_reg),
        .in_value({1'b0, prod7_reg}),
        .in_side(side7_reg),
        .out_valid(vd), .out_root(droot),
        .out_side({ok_d, onum_d, oden_d, bnum_d, bden_d, ocase_d, oneg_d, bzero_d, bneg_d})
    );

    // Angle rotators for the apex direction and the bearing.
    logic                  vo, vb;
    logic [ANGW-1:0]       oang, bang;
    logic                  ok_o, oneg_o, bzero_b, bneg_b;
    logic [31:0]           dist_o;
    tsl_pkg::orient_case_t ocase_o;

    tsl_cordic #(.MW(PW), .SPS(2), .SBW(OSB)) u_orient (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(vd),
        .in_num(onum_d), .in_den(oden_d),
        .in_side({ok_d, 32'(droot[RTW-1:4]), ocase_d, oneg_d}),
        .out_valid(vo), .out_angle(oang),
        .out_side({ok_o, dist_o, ocase_o, oneg_o})
    );

    tsl_cordic #(.MW(PW), .SPS(2), .SBW(2)) u_bearing (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(vd),
        .in_num(bnum_d), .in_den(bden_d),
        .in_side({bzero_d, bneg_d}),
        .out_valid(vb), .out_angle(bang),
        .out_side({bzero_b, bneg_b})
    );

    // Output stage: fold angles onto the circle and the bearing range.
    logic [tsl_pkg::OUT_W-1:0] out_data_reg;
    logic [tsl_pkg::OUT_W-1:0] out_data_next;

    always_comb
    begin
        logic signed [15:0] a16;
        logic signed [15:0] b16;
        logic signed [15:0] o16;
        logic signed [15:0] t16;
        a16 = oneg_o ? -$signed({3'b000, oang}) : $signed({3'b000, oang});
        b16 = bneg_b ? -$signed({3'b000, bang}) : $signed({3'b000, bang});
        case (ocase_o)
            tsl_pkg::ORI_HALF:  o16 = tsl_pkg::ANG_180 + a16;
            tsl_pkg::ORI_PLAIN: o16 = a16;
            tsl_pkg::ORI_FULL:  o16 = tsl_pkg::ANG_360 + a16;
            default:            o16 = tsl_pkg::ANG_270;
        endcase
        if (bzero_b)
            t16 = '0;
        else
        begin
            t16 = tsl_pkg::ANG_90 - b16;
            if (t16 > tsl_pkg::ANG_90)
                t16 = t16 - tsl_pkg::ANG_180;
        end
        if (ok_o)
            out_data_next = {2'b00, t16[13:0], o16[14:0], dist_o, 1'b1};
        else
            out_data_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vo && vb;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tdata = out_data_reg;

    `TSL_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, v0_reg, "accepted polygon did not enter the pipeline")
    `TSL_ASSERT_IMPL(a_lanes_aligned, 1'b1, (vq0 == vq1) && (vq0 == vq2) && (vo == vb), "parallel lanes lost alignment")
    `TSL_ASSERT_IMPL(a_reject_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[tsl_pkg::OUT_W-1:1] == '0, "rejected polygon has nonzero fields")
    `TSL_ASSERT_IMPL(a_angle_range, m_axis_tvalid && m_axis_tdata[0], (m_axis_tdata[47:33] <= 15'd23040) && ($signed(m_axis_tdata[61:48]) >= -14'sd5759) && ($signed(m_axis_tdata[61:48]) <= 14'sd5760), "angle out of range")

endmodule
